/* hw/rtl/rfs_pkg.sv */
package rfs_pkg;

  // sizing
  localparam int MAX_FIELD_COUNT = 32;
  localparam int FIELD_BYTES     = 256;
  localparam int SEPARATOR_SLOTS = 7;

  localparam int LEN_W    = $clog2(FIELD_BYTES);
  localparam int FCNT_W   = $clog2(MAX_FIELD_COUNT + 1);
  localparam int IDX_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int RECNUM_W = 32;
  localparam int SEPS_W   = 56;
  localparam int SCNT_W   = 3;
  localparam int CIDX_W   = 2;

  // request queue between classifier and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // character codes
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_WS_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SEP_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SEP_CHARS = 2'd2;

  // reset values of the configuration
  localparam logic                 RST_WS_MODE   = 1'b1;
  localparam logic [SCNT_W-1:0]    RST_SEP_COUNT = 3'd1;
  localparam logic [SEPS_W-1:0]    RST_SEP_CHARS = 56'h20;

  // result slots within one bundle, in emission order
  localparam logic [1:0] SLOT_F0  = 2'd0;
  localparam logic [1:0] SLOT_F1  = 2'd1;
  localparam logic [1:0] SLOT_SUM = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              fl;
  } field_res_t;

  // every result caused by one input byte
  typedef struct packed {
    field_res_t          f0;
    field_res_t          f1;
    logic                sum_vld;
    logic [FCNT_W-1:0]   count;
    logic [RECNUM_W-1:0] recnum;
  } bundle_t;

  function automatic field_res_t mk_field(logic [BYTE_W-1:0] d, logic [IDX_W-1:0] i,
                                          logic l);
    field_res_t r;
    r.vld  = 1'b1;
    r.data = d;
    r.idx  = i;
    r.fl   = l;
    return r;
  endfunction

endpackage

/* hw/rtl/rfs_front.sv */
module rfs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfs_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rfs_pkg::SEPS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rfs_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_record_end,
  input  logic                          q_full,
  output logic                          push,
  output rfs_pkg::bundle_t              push_bundle
);
  import rfs_pkg::*;

  logic                  ws_mode_r;
  logic [SCNT_W-1:0]     sep_count_r;
  logic [SEPS_W-1:0]     sep_chars_r;

  logic                  held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]     held_byte_r, held_byte_nxt;
  logic [IDX_W-1:0]      held_index_r, held_index_nxt;
  logic [FCNT_W-1:0]     fields_seen_r, fields_seen_nxt;
  logic [LEN_W-1:0]      cur_len_r, cur_len_nxt;
  logic                  inside_r, inside_nxt;
  logic                  done_r, done_nxt;
  logic [RECNUM_W-1:0]   records_r, records_nxt;

  logic                  accept;
  logic                  line_end;
  logic                  is_sep;
  bundle_t               bnd;

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_mode_r   <= RST_WS_MODE;
      sep_count_r <= RST_SEP_COUNT;
      sep_chars_r <= RST_SEP_CHARS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WS_MODE:   ws_mode_r   <= cfg_data[0];
        REG_SEP_COUNT: sep_count_r <= cfg_data[SCNT_W-1:0];
        REG_SEP_CHARS: sep_chars_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte classification: space and tab in whitespace mode, else a parallel compare against the separator slots
  assign line_end = (in_byte == CH_LF) || (in_byte == CH_CR);

  always_comb begin
    is_sep = 1'b0;
    if (ws_mode_r) begin
      is_sep = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    end else begin
      for (int i = 0; i < SEPARATOR_SLOTS; i++) begin
        if ((4'(i) < {1'b0, sep_count_r}) &&
            (sep_chars_r[i*BYTE_W +: BYTE_W] == in_byte)) begin
          is_sep = 1'b1;
        end
      end
    end
  end

  // field tracking and result bundle for one byte
  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_byte_nxt   = held_byte_r;
    held_index_nxt  = held_index_r;
    fields_seen_nxt = fields_seen_r;
    cur_len_nxt     = cur_len_r;
    inside_nxt      = inside_r;
    done_nxt        = done_r;
    records_nxt     = records_r;
    bnd             = '0;

    if (!done_r) begin
      if (line_end || is_sep) begin
        if (held_valid_nxt) begin
          bnd.f0         = mk_field(held_byte_nxt, held_index_nxt, 1'b1);
          held_valid_nxt = 1'b0;
        end
        if (inside_nxt) begin
          inside_nxt      = 1'b0;
          fields_seen_nxt = fields_seen_nxt + 1'b1;
        end
        cur_len_nxt = '0;
        if (line_end) begin
          done_nxt = 1'b1;
        end
      end else if (inside_nxt || (fields_seen_nxt < FCNT_W'(MAX_FIELD_COUNT))) begin
        if (!inside_nxt) begin
          inside_nxt  = 1'b1;
          cur_len_nxt = '0;
        end
        if (held_valid_nxt) begin
          bnd.f0         = mk_field(held_byte_nxt, held_index_nxt, 1'b0);
          held_valid_nxt = 1'b0;
        end
        cur_len_nxt = cur_len_nxt + 1'b1;
        // long field closes on this byte
        if (cur_len_nxt == LEN_W'(FIELD_BYTES - 1)) begin
          bnd.f1          = mk_field(in_byte, IDX_W'(fields_seen_nxt), 1'b1);
          inside_nxt      = 1'b0;
          fields_seen_nxt = fields_seen_nxt + 1'b1;
          cur_len_nxt     = '0;
        end else begin
          held_valid_nxt = 1'b1;
          held_byte_nxt  = in_byte;
          held_index_nxt = IDX_W'(fields_seen_nxt);
        end
      end
    end

    // end of record: flush held byte and add the summary
    if (in_record_end) begin
      if (held_valid_nxt) begin
        bnd.f1 = mk_field(held_byte_nxt, held_index_nxt, 1'b1);
      end
      if (inside_nxt) begin
        fields_seen_nxt = fields_seen_nxt + 1'b1;
      end
      records_nxt     = records_r + 1'b1;
      bnd.sum_vld     = 1'b1;
      bnd.count       = fields_seen_nxt;
      bnd.recnum      = records_nxt;
      fields_seen_nxt = '0;
      cur_len_nxt     = '0;
      inside_nxt      = 1'b0;
      done_nxt        = 1'b0;
      held_valid_nxt  = 1'b0;
    end
  end

  // handshake towards the queue
  assign in_stall    = q_full;
  assign accept      = in_valid && !in_stall;
  assign push        = accept && (bnd.f0.vld || bnd.f1.vld || bnd.sum_vld);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_byte_r   <= '0;
      held_index_r  <= '0;
      fields_seen_r <= '0;
      cur_len_r     <= '0;
      inside_r      <= 1'b0;
      done_r        <= 1'b0;
      records_r     <= '0;
    end else if (accept) begin
      held_valid_r  <= held_valid_nxt;
      held_byte_r   <= held_byte_nxt;
      held_index_r  <= held_index_nxt;
      fields_seen_r <= fields_seen_nxt;
      cur_len_r     <= cur_len_nxt;
      inside_r      <= inside_nxt;
      done_r        <= done_nxt;
      records_r     <= records_nxt;
    end
  end

endmodule

/* hw/rtl/rfs_queue.sv */
module rfs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rfs_pkg::bundle_t push_bundle,
  output logic             full,
  input  logic             pop,
  output logic             head_vld,
  output rfs_pkg::bundle_t head
);
  import rfs_pkg::*;

  bundle_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_bundle;
    end
  end

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_vld = (count_r != '0);
  assign head     = q_mem[rd_ptr_r];

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("request pushed into a full queue");

endmodule

/* hw/rtl/rfs_back.sv */
module rfs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_vld,
  input  rfs_pkg::bundle_t              head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [rfs_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [rfs_pkg::IDX_W-1:0]     out_field_index,
  output logic                          out_field_last,
  output logic [rfs_pkg::FCNT_W-1:0]    out_field_count,
  output logic [rfs_pkg::RECNUM_W-1:0]  out_record_number,
  output logic                          out_last
);
  import rfs_pkg::*;

  logic [1:0]           phase_r;
  logic                 out_valid_r;
  logic                 kind_r;
  logic [BYTE_W-1:0]    data_r;
  logic [IDX_W-1:0]     index_r;
  logic                 flast_r;
  logic [FCNT_W-1:0]    count_r;
  logic [RECNUM_W-1:0]  recnum_r;
  logic                 last_r;

  logic [2:0]           slot_v;
  logic [2:0]           pend;
  logic [1:0]           sel;
  logic                 later;
  logic                 load;
  field_res_t           sel_f;

  // pending slots at or after the current phase
  assign slot_v = {head.sum_vld, head.f1.vld, head.f0.vld};

  always_comb begin
    pend = '0;
    for (int i = 0; i < 3; i++) begin
      pend[i] = slot_v[i] && (2'(i) >= phase_r);
    end
    if (pend[SLOT_F0]) begin
      sel = SLOT_F0;
    end else if (pend[SLOT_F1]) begin
      sel = SLOT_F1;
    end else begin
      sel = SLOT_SUM;
    end
    later = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (pend[i] && (2'(i) > sel)) begin
        later = 1'b1;
      end
    end
  end

  always_comb begin
    case (sel)
      SLOT_F0: sel_f = head.f0;
      SLOT_F1: sel_f = head.f1;
      default: sel_f = '0;
    endcase
  end

  // output register loads whenever a request is queued and the register is empty or being taken
  assign load = head_vld && (!out_valid_r || !out_stall);
  assign pop  = load && !later;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= head_vld;
      if (head_vld) begin
        phase_r <= later ? sel + 1'b1 : '0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= (sel == SLOT_SUM);
      last_r <= !later;
      if (sel == SLOT_SUM) begin
        data_r   <= '0;
        index_r  <= '0;
        flast_r  <= 1'b0;
        count_r  <= head.count;
        recnum_r <= head.recnum;
      end else begin
        data_r   <= sel_f.data;
        index_r  <= sel_f.idx;
        flast_r  <= sel_f.fl;
        count_r  <= '0;
        recnum_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_field_index   = index_r;
  assign out_field_last    = flast_r;
  assign out_field_count   = count_r;
  assign out_record_number = recnum_r;
  assign out_last          = last_r;

  // checks
  a_sum_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r) |-> last_r)
    else $error("record summary not marked as final result");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("pop from an empty queue");

  a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> (pend != 3'b000))
    else $error("queued request has no result left to emit");

endmodule

/* hw/rtl/record_field_splitter.sv */
// channel   dir  handshake              payload
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in   in_valid/in_stall      in_byte, in_record_end
// out       out  out_valid/out_stall    out_kind, out_data_byte, out_field_index,
//                                       out_field_last, out_field_count,
//                                       out_record_number, out_last
//
// one byte accepted per cycle while in_stall is low; results leave at one per cycle
// from the output register while out_stall is low; a byte causes zero to three results,
// so the emitter and its 4-entry queue set the sustained rate
// in_stall rises only while the request queue is full; out_stall holds the output register
// synchronous active-low reset clears field state, record count and queue, and restores
// the whitespace separator configuration
module record_field_splitter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfs_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rfs_pkg::SEPS_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rfs_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_record_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [rfs_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [rfs_pkg::IDX_W-1:0]     out_field_index,
  output logic                          out_field_last,
  output logic [rfs_pkg::FCNT_W-1:0]    out_field_count,
  output logic [rfs_pkg::RECNUM_W-1:0]  out_record_number,
  output logic                          out_last
);
  import rfs_pkg::*;

  logic     q_full;
  logic     push;
  bundle_t  push_bundle;
  logic     pop;
  logic     head_vld;
  bundle_t  head;

  // classifier
  rfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_record_end (in_record_end),
    .q_full        (q_full),
    .push          (push),
    .push_bundle   (push_bundle)
  );

  // request queue
  rfs_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .head_vld    (head_vld),
    .head        (head)
  );

  // result emitter
  rfs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_vld          (head_vld),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_field_index   (out_field_index),
    .out_field_last    (out_field_last),
    .out_field_count   (out_field_count),
    .out_record_number (out_record_number),
    .out_last          (out_last)
  );

endmodule
